>>> design/mcs_pkg.sv
// mcs_pkg: shared types, constants and the count update for the rope cut table
// no dependencies
package mcs_pkg;

    localparam int LEN_W = 10;
    localparam int CNT_W = 11;
    localparam logic [CNT_W-1:0] UNREACH = 11'h7FF;

    typedef struct packed {
        logic [LEN_W-1:0] piece_c;
        logic [LEN_W-1:0] piece_b;
        logic [LEN_W-1:0] piece_a;
        logic [LEN_W-1:0] total_length;
    } t_query;

    typedef struct packed {
        logic             idle;
        logic             done;
        logic [LEN_W-1:0] result;
    } t_seq_status;

    // best count after trying one piece whose remainder entry holds prev
    function automatic logic [CNT_W-1:0] f_take(
        input logic [CNT_W-1:0] best,
        input logic [CNT_W-1:0] prev,
        input logic             use_it
    );
        logic [CNT_W-1:0] cand;
        cand = prev + 11'd1;
        if (use_it && (prev != UNREACH) && ((best == UNREACH) || (cand > best))) begin
            return cand;
        end
        return best;
    endfunction

endpackage

>>> design/max_cut_segments_dp_unit.sv
// max_cut_segments_dp_unit: largest piece count of an exact rope split
// a length of 1 or more runs the table fill; a zero or out-of-range length gives a result
// of 0 without a fill; one query at a time, each table entry
// takes three reads on the single read port of the table memory
// synchronous active-low reset clears control state; the table needs no clearing pass
module max_cut_segments_dp_unit #(
    parameter int MAX_LEN = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // total_length, piece_a, piece_b, piece_c
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata   // max_pieces, zero fill
);
    import mcs_pkg::*;

    localparam int AW = $clog2(MAX_LEN);

    t_query           query;
    t_seq_status      status;
    logic             start;
    logic             ack;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [CNT_W-1:0] wdata;
    logic [AW-1:0]    raddr;
    logic [CNT_W-1:0] rdata;
    logic             r_out_valid;
    logic [LEN_W-1:0] r_out_data;

    assign query.total_length = i_s_axis_tdata[9:0];
    assign query.piece_a      = i_s_axis_tdata[19:10];
    assign query.piece_b      = i_s_axis_tdata[29:20];
    assign query.piece_c      = i_s_axis_tdata[39:30];

    assign o_s_axis_tready = status.idle;
    assign start           = i_s_axis_tvalid && status.idle;
    assign ack             = status.done && (!r_out_valid || i_m_axis_tready);

    mcs_fill_seq #(
        .MAX_LEN(MAX_LEN)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_query  (query),
        .i_ack    (ack),
        .o_status (status),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_raddr  (raddr),
        .i_rdata  (rdata)
    );

    mcs_table_ram #(
        .DEPTH(MAX_LEN)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (ack) begin
                r_out_valid <= 1'b1;
                r_out_data  <= status.result;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_data};

endmodule

>>> design/mcs_table_ram.sv
// mcs_table_ram: best count table, one write and one read port, registered read
// write-to-read bypass when both ports hit the same entry; uses mcs_pkg
module mcs_table_ram #(
    parameter int DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [mcs_pkg::CNT_W-1:0]  i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [mcs_pkg::CNT_W-1:0]  o_rdata
);
    import mcs_pkg::*;

    logic [CNT_W-1:0] r_mem [DEPTH];
    logic [CNT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/mcs_fill_seq.sv
// mcs_fill_seq: fills the table entry by entry, three table reads per entry
// uses mcs_pkg; drives the write and read ports of mcs_table_ram
module mcs_fill_seq #(
    parameter int MAX_LEN = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  mcs_pkg::t_query                   i_query,
    input  logic                              i_ack,
    output mcs_pkg::t_seq_status              o_status,
    output logic                              o_we,
    output logic [$clog2(MAX_LEN)-1:0]        o_waddr,
    output logic [mcs_pkg::CNT_W-1:0]         o_wdata,
    output logic [$clog2(MAX_LEN)-1:0]        o_raddr,
    input  logic [mcs_pkg::CNT_W-1:0]         i_rdata
);
    import mcs_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam logic [16:0] MAX_LEN_V = 17'(MAX_LEN);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_DONE} t_state;

    t_state           r_state;
    logic [1:0]       r_phase;
    logic             r_pend;
    logic             r_rv;
    logic [LEN_W-1:0] r_pos;
    logic [LEN_W-1:0] r_fill;
    logic [LEN_W-1:0] r_n;
    logic [LEN_W-1:0] r_pa;
    logic [LEN_W-1:0] r_pb;
    logic [LEN_W-1:0] r_pc;
    logic [CNT_W-1:0] r_best;
    logic [LEN_W-1:0] r_result;

    logic             n_ok;
    logic [CNT_W-1:0] take;
    logic [LEN_W-1:0] len;
    logic             rd_ok;
    logic [LEN_W-1:0] diff;
    logic [LEN_W-1:0] fill_next;
    logic [LEN_W-1:0] waddr_len;
    logic [AW+LEN_W-1:0] raddr_ext;
    logic [AW+LEN_W-1:0] waddr_ext;

    always_comb begin
        n_ok      = ({7'd0, i_query.total_length} < MAX_LEN_V);
        take      = f_take(r_best, i_rdata, r_rv);
        case (r_phase)
            2'd1:    len = r_pb;
            2'd2:    len = r_pc;
            default: len = r_pa;
        endcase
        rd_ok     = (len != '0) && (len <= r_pos);
        diff      = r_pos - len;
        fill_next = r_fill + 10'd1;
        o_we      = ((r_state == S_IDLE) && i_start && n_ok)
                  || ((r_state == S_RUN) && (r_phase == 2'd0) && r_pend)
                  || (r_state == S_DRAIN);
        waddr_len = (r_state == S_IDLE) ? '0 : fill_next;
        o_wdata   = (r_state == S_IDLE) ? '0 : take;
        raddr_ext = {{AW{1'b0}}, diff};
        waddr_ext = {{AW{1'b0}}, waddr_len};
        o_raddr   = raddr_ext[AW-1:0];
        o_waddr   = waddr_ext[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 2'd0;
            r_pend  <= 1'b0;
            r_rv    <= 1'b0;
            r_fill  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_rv <= 1'b0;
                    if (i_start) begin
                        r_n  <= i_query.total_length;
                        r_pa <= i_query.piece_a;
                        r_pb <= i_query.piece_b;
                        r_pc <= i_query.piece_c;
                        if (!n_ok || (i_query.total_length == '0)) begin
                            r_result <= '0;
                            r_state  <= S_DONE;
                        end else begin
                            r_pos   <= 10'd1;
                            r_phase <= 2'd0;
                            r_pend  <= 1'b0;
                            r_best  <= UNREACH;
                            r_state <= S_RUN;
                        end
                        if (n_ok) begin
                            r_fill <= '0;
                        end
                    end
                end
                S_RUN: begin
                    r_rv <= rd_ok;
                    if (r_phase == 2'd0) begin
                        if (r_pend) begin
                            r_fill <= fill_next;
                        end
                        r_best  <= UNREACH;
                        r_phase <= 2'd1;
                    end else if (r_phase == 2'd1) begin
                        r_best  <= take;
                        r_phase <= 2'd2;
                    end else begin
                        r_best  <= take;
                        r_phase <= 2'd0;
                        if (r_pos == r_n) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_pos  <= r_pos + 10'd1;
                            r_pend <= 1'b1;
                        end
                    end
                end
                S_DRAIN: begin
                    r_rv     <= 1'b0;
                    r_fill   <= fill_next;
                    r_result <= (take == UNREACH) ? '0 : take[LEN_W-1:0];
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (i_ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_status.idle   = (r_state == S_IDLE);
    assign o_status.done   = (r_state == S_DONE);
    assign o_status.result = r_result;

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("phase counter out of range");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> ((r_pos != '0) && (r_pos <= r_n)))
        else $error("entry position outside the query length");

    a_fill_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RUN) && (r_phase == 2'd0) && r_pend) |-> (fill_next == r_pos - 10'd1))
        else $error("pending write does not target the previous entry");

    a_drain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (fill_next == r_n))
        else $error("last write does not target the full length");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && !i_ack) |=> (r_state == S_DONE))
        else $error("result dropped before it was taken");

endmodule
